### rtl/tif_pkg.sv
// Package for the tensor index fill block: field widths, request codes,
// register indexes and the structs passed between its modules.
// Depends on nothing; every file of the block but tif_ram imports it.
package tif_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CIDX_W  = 3;

  // The selection map is stored as rows of ROW_W bits.
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned BIT_W   = 4;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INDEX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ELEM  = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_ROW_COUNT       = 3'd0;
  localparam logic [CIDX_W-1:0] REG_COL_COUNT       = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FILL_COLUMNS    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SKIP_UNSELECTED = 3'd3;
  localparam logic [CIDX_W-1:0] REG_FILL_BITS       = 3'd4;

  // Normalized index from the index unit.
  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] pos;
  } idx_norm_t;

  // Current element position from the position walker.
  typedef struct packed {
    logic [POS_W-1:0] sel_pos;
    logic             last;
  } elem_pos_t;

endpackage

### rtl/tif_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tif_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### rtl/tif_norm.sv
// Index normalizer: wraps a negative index by the selected dimension size and
// checks the result against the size and the map depth. Depends on tif_pkg.
module tif_norm #(
  parameter int unsigned DIM_MAX = 4096
) (
  input  logic [tif_pkg::DATA_W-1:0] idx,
  input  logic [tif_pkg::POS_W-1:0]  size,
  output tif_pkg::idx_norm_t         norm
);
  import tif_pkg::*;

  logic signed [DATA_W:0] sum;
  logic signed [DATA_W:0] addend;

  // A negative index gets the size added once; the result is then range checked.
  always_comb begin
    addend   = idx[DATA_W-1] ? $signed({{(DATA_W + 1 - POS_W){1'b0}}, size})
                             : '0;
    sum      = $signed({idx[DATA_W-1], idx}) + addend;
    norm.ok  = !sum[DATA_W]
               && (sum[DATA_W-1:0] < {{(DATA_W - POS_W){1'b0}}, size})
               && (sum[DATA_W-1:0] < DATA_W'(DIM_MAX));
    norm.pos = sum[POS_W-1:0];
  end

endmodule

### rtl/tif_walk.sv
// Row and column position counters that walk the tensor in row-major order.
// Depends on tif_pkg.
module tif_walk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      step,
  input  logic [tif_pkg::POS_W-1:0] row_count,
  input  logic [tif_pkg::POS_W-1:0] col_count,
  input  logic                      fill_columns,
  output tif_pkg::elem_pos_t        cur
);
  import tif_pkg::*;

  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic             row_end;

  // End-of-row and end-of-tensor tests; a zero count wraps on every element.
  always_comb begin
    row_end     = ({1'b0, col_r} + (POS_W + 1)'(1)) >= {1'b0, col_count};
    cur.last    = row_end && (({1'b0, row_r} + (POS_W + 1)'(1)) >= {1'b0, row_count});
    cur.sel_pos = fill_columns ? col_r : row_r;
  end

  // Next position after a start or an element.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (clear) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (step) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = cur.last ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

### rtl/tensor_index_fill.sv
// Channel  | ports                                         | handshake
// request  | in_mode, in_index_value, in_element_value     | start && !busy
// result   | out_value, out_write_enable, out_last_element | out_valid, one cycle
// config   | cfg_index, cfg_data                           | cfg_valid && cfg_ready
//
// Elements may follow back to back, and each result appears in the cycle after
// its request, since the map memory read is registered.
// An index request holds busy while its row is written back: the map row is read
// on the accepting edge and written back in the busy cycle that follows.
// A start request, and reset, run a clearing pass over the map memory, one row a
// cycle, busy until every row is cleared.
// Configuration writes are taken in every cycle. Results cannot be stalled.
module tensor_index_fill #(
  parameter int unsigned DIM_MAX = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [tif_pkg::MODE_W-1:0] in_mode,
  input  logic [tif_pkg::DATA_W-1:0] in_index_value,
  input  logic [tif_pkg::DATA_W-1:0] in_element_value,
  output logic                       out_valid,
  output logic [tif_pkg::DATA_W-1:0] out_value,
  output logic                       out_write_enable,
  output logic                       out_last_element,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tif_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tif_pkg::DATA_W-1:0] cfg_data
);
  import tif_pkg::*;

  localparam int unsigned ROWS     = (DIM_MAX + ROW_W - 1) / ROW_W;
  localparam int unsigned AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLEAR  = 2'd1;
  localparam logic [1:0] ST_IDX_WR = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;

  logic [POS_W-1:0]  row_count_r, col_count_r;
  logic              fill_columns_r, skip_unselected_r;
  logic [DATA_W-1:0] fill_bits_r;

  logic              accept, acc_start, acc_index, acc_elem;
  idx_norm_t         norm;
  elem_pos_t         cur;

  logic              idx_ok_r;
  logic [BIT_W-1:0]  idx_bit_r;
  logic [AW-1:0]     idx_row_r;

  logic              e_vld_r;
  logic [DATA_W-1:0] e_val_r;
  logic [BIT_W-1:0]  e_bit_r;
  logic              e_inrng_r;
  logic              e_last_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;
  logic              sel;

  // Request decode.
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign acc_start = accept && (in_mode == MODE_START);
  assign acc_index = accept && (in_mode == MODE_INDEX);
  assign acc_elem  = accept && (in_mode == MODE_ELEM);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r       <= POS_W'(1);
      col_count_r       <= POS_W'(1);
      fill_columns_r    <= 1'b0;
      skip_unselected_r <= 1'b0;
      fill_bits_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_COUNT:       row_count_r       <= cfg_data[POS_W-1:0];
        REG_COL_COUNT:       col_count_r       <= cfg_data[POS_W-1:0];
        REG_FILL_COLUMNS:    fill_columns_r    <= cfg_data[0];
        REG_SKIP_UNSELECTED: skip_unselected_r <= cfg_data[0];
        REG_FILL_BITS:       fill_bits_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Index normalization against the size of the selected dimension.
  tif_norm #(
    .DIM_MAX (DIM_MAX)
  ) u_norm (
    .idx  (in_index_value),
    .size (fill_columns_r ? col_count_r : row_count_r),
    .norm (norm)
  );

  // Element position counters.
  tif_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (acc_start),
    .step         (acc_elem),
    .row_count    (row_count_r),
    .col_count    (col_count_r),
    .fill_columns (fill_columns_r),
    .cur          (cur)
  );

  // Map memory ports: clearing pass, index row write-back, and reads on accept.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == ST_IDX_WR) begin
      ram_we    = idx_ok_r;
      ram_waddr = idx_row_r;
      ram_wdata = ram_rdata | (ROW_W'(1) << idx_bit_r);
    end
    ram_re    = acc_index || acc_elem;
    ram_raddr = acc_index ? AW'(norm.pos >> BIT_W) : AW'(cur.sel_pos >> BIT_W);
  end

  tif_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Controller: reset and start run the clearing pass, an index waits one write.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_start) begin
          state_nxt   = ST_CLEAR;
          clr_cnt_nxt = '0;
        end else if (acc_index) begin
          state_nxt = ST_IDX_WR;
        end
      end
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDX_WR: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      idx_ok_r  <= 1'b0;
      e_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (acc_index) begin
        idx_ok_r <= norm.ok;
      end
      e_vld_r   <= acc_elem;
    end
  end

  // Payload held for the index write-back and the element result.
  always_ff @(posedge clk) begin
    if (acc_index) begin
      idx_bit_r <= norm.pos[BIT_W-1:0];
      idx_row_r <= AW'(norm.pos >> BIT_W);
    end
    if (acc_elem) begin
      e_val_r   <= in_element_value;
      e_bit_r   <= cur.sel_pos[BIT_W-1:0];
      e_inrng_r <= ({1'b0, cur.sel_pos} < (POS_W + 1)'(DIM_MAX));
      e_last_r  <= cur.last;
    end
  end

  // Result: fill the element when its row or column is marked in the map.
  assign sel              = e_inrng_r && ram_rdata[e_bit_r];
  assign out_valid        = e_vld_r;
  assign out_value        = sel ? fill_bits_r : e_val_r;
  assign out_write_enable = sel || !skip_unselected_r;
  assign out_last_element = e_last_r;

endmodule

### rtl/tif_chk.sv
// Port-level checker for tensor_index_fill, attached by the bind at the end.
// Depends on tif_pkg.
module tif_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [tif_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid
);
  import tif_pkg::*;

  // An element request always gives a result in the next cycle.
  a_elem_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_ELEM |=> out_valid)
    else $error("element request without a result");

  // A result only follows an accepted element request.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) |-> $past(start && !busy && in_mode == MODE_ELEM))
    else $error("result without an element request");

  // A start request begins the clearing pass.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_START |=> busy)
    else $error("start request did not begin the clearing pass");

  // An index request holds off the next request for its write-back.
  a_index_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_INDEX |=> busy)
    else $error("index request did not hold busy");

endmodule

bind tensor_index_fill tif_chk u_tif_chk (.*);
